/* sv/dpv_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package dpv_pkg;

    // Field and register widths
    localparam int SAMPLE_BITS = 10;
    localparam int GAIN_W      = 16;
    localparam int PERIOD_W    = 10;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Multiplicand width: widest of ki*period and kd*2000
    localparam int COEF_W      = 27;
    // Divisor width: widest of full scale, 256*period and 512000
    localparam int DIV_D_W     = 19;

    // Converter full scale and its rounding half
    localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = {SAMPLE_BITS{1'b1}};
    localparam logic [SAMPLE_BITS-1:0] HALF_FS    = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

    // Q8.8 gain scaling
    localparam int                  P_SHIFT = 8;
    localparam logic [P_SHIFT-1:0]  P_HALF  = {1'b1, {(P_SHIFT-1){1'b0}}};

    // Integral term divisor 256*2000 and its half
    localparam logic [DIV_D_W-1:0]  I_DIVISOR = 19'd512000;
    localparam logic [DIV_D_W-1:0]  I_HALF    = 19'd256000;

    // Derivative term scale 2/T with T in milliseconds
    localparam int                   D_SCALE_W = 11;
    localparam logic [D_SCALE_W-1:0] D_SCALE   = 11'd2000;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_PROP       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_INTEGRAL   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_DERIVATIVE = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PERIOD_MS       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SETPOINT        = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_RUN_ENABLE      = 3'd5;

    // Request kinds
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_CLEAR  = 1'b1;

    typedef struct packed {
        logic                   req_type;
        logic [SAMPLE_BITS-1:0] measurement;
    } dpv_in_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] drive;
        logic                   clamped_high;
        logic                   clamped_low;
    } dpv_out_t;

    // Status of a serial arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } dpv_unit_stat_t;

endpackage
`default_nettype wire

/* sv/discrete_pid_velocity_form.sv */
`timescale 1ns / 1ps
`default_nettype none
// A sample request runs through three passes of the bit-serial divider and five of the
// bit-serial multiplier, each retiring one bit per cycle, before its result is offered.
// Requests are accepted only in the idle state, so one sample request is finished before
// another is taken; a clear or ignored request leaves the block idle. A result left waiting
// holds the next one in the output state.
// Reset (aresetn low, synchronous) restores the register defaults and zeroes the history.
module discrete_pid_velocity_form
    import dpv_pkg::*;
#(
    parameter int ACC_FRAC_BITS = 16
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     cfg_valid,
    output logic                    cfg_ready,
    input  wire  [CFG_INDEX_W-1:0]  cfg_index,
    input  wire  [CFG_DATA_W-1:0]   cfg_data,
    input  wire                     s_valid,
    output logic                    s_ready,
    input  wire  dpv_in_t           s_data,
    output logic                    m_valid,
    input  wire                     m_ready,
    output dpv_out_t                m_data
);

    localparam int F      = ACC_FRAC_BITS;
    localparam int EW     = F + 2;
    localparam int MAG_W  = F + 3;
    localparam int SUM_W  = F + 26;
    localparam int PROD_W = COEF_W + MAG_W;
    localparam int YW     = 32;
    localparam int S      = SAMPLE_BITS;

    localparam logic [YW-2:0] ONE_FIXED = {{(YW-2-F){1'b0}}, 1'b1, {F{1'b0}}};

    // Sequencer states
    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_E0_GO = 5'd1;
    localparam logic [4:0] ST_E0_WT = 5'd2;
    localparam logic [4:0] ST_P_GO  = 5'd3;
    localparam logic [4:0] ST_P_WT  = 5'd4;
    localparam logic [4:0] ST_I1_GO = 5'd5;
    localparam logic [4:0] ST_I1_WT = 5'd6;
    localparam logic [4:0] ST_I2_GO = 5'd7;
    localparam logic [4:0] ST_I2_WT = 5'd8;
    localparam logic [4:0] ST_I3_GO = 5'd9;
    localparam logic [4:0] ST_I3_WT = 5'd10;
    localparam logic [4:0] ST_D1_GO = 5'd11;
    localparam logic [4:0] ST_D1_WT = 5'd12;
    localparam logic [4:0] ST_D2_GO = 5'd13;
    localparam logic [4:0] ST_D2_WT = 5'd14;
    localparam logic [4:0] ST_D3_GO = 5'd15;
    localparam logic [4:0] ST_D3_WT = 5'd16;
    localparam logic [4:0] ST_FIN   = 5'd17;
    localparam logic [4:0] ST_OUT   = 5'd18;

    // Configuration registers
    logic [GAIN_W-1:0]   gain_prop_reg;
    logic [GAIN_W-1:0]   gain_integral_reg;
    logic [GAIN_W-1:0]   gain_derivative_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic [S-1:0]        setpoint_reg;
    logic                run_reg;

    // Sequencer and datapath registers
    logic [4:0]       state_reg, state_next;
    logic [S-1:0]     meas_reg, meas_next;
    logic [EW-1:0]    e_cur_reg, e_cur_next;
    logic [EW-1:0]    e1_reg, e1_next;
    logic [EW-1:0]    e2_reg, e2_next;
    logic [YW-1:0]    ol_reg, ol_next;
    logic [YW-1:0]    ob_reg, ob_next;
    logic [SUM_W-1:0] acc_reg, acc_next;
    logic             m_valid_reg, m_valid_next;
    dpv_out_t         m_data_reg, m_data_next;

    // Serial unit connections
    logic                 mul_start;
    logic [COEF_W-1:0]    mul_a;
    logic [MAG_W-1:0]     mul_b;
    logic [PROD_W-1:0]    mul_prod;
    dpv_unit_stat_t       mul_stat;
    logic                 div_start;
    logic [PROD_W-1:0]    div_num;
    logic [DIV_D_W-1:0]   div_den;
    logic [PROD_W-1:0]    div_quo;
    dpv_unit_stat_t       div_stat;

    // Narrow combinational terms
    logic [PERIOD_W-1:0]  per_eff;
    logic [S:0]           diff, diff_neg;
    logic [S-1:0]         diff_mag;
    logic [EW-1:0]        e_mag, e_mag_neg;
    logic [F+2:0]         d_p, d_p_neg;
    logic [F+3:0]         s_i, s_i_neg, s_d, s_d_neg;
    logic [MAG_W-1:0]     d_p_abs, s_i_abs, s_d_abs;
    logic [SUM_W-1:0]     ob_ext;
    logic [PROD_W-1:0]    p_round;
    logic [SUM_W-1:0]     p_term, q_term;
    logic                 sat_fit;
    logic [YW-1:0]        y_sat;
    logic                 y_high, y_low;
    logic [F+S:0]         y_scaled;
    logic [S-1:0]         drive_val;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_prop_reg       <= 16'd256;
            gain_integral_reg   <= 16'd1280;
            gain_derivative_reg <= '0;
            period_reg          <= 10'd10;
            setpoint_reg        <= '0;
            run_reg             <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_GAIN_PROP:       gain_prop_reg       <= cfg_data[GAIN_W-1:0];
                REG_GAIN_INTEGRAL:   gain_integral_reg   <= cfg_data[GAIN_W-1:0];
                REG_GAIN_DERIVATIVE: gain_derivative_reg <= cfg_data[GAIN_W-1:0];
                REG_PERIOD_MS:       period_reg          <= cfg_data[PERIOD_W-1:0];
                REG_SETPOINT:        setpoint_reg        <= cfg_data[S-1:0];
                REG_RUN_ENABLE:      run_reg             <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Treat a zero period as one millisecond
    assign per_eff = (period_reg == '0) ? PERIOD_W'(1) : period_reg;

    // Setpoint minus measurement, split into sign and magnitude
    assign diff     = {1'b0, setpoint_reg} - {1'b0, meas_reg};
    assign diff_neg = -diff;
    assign diff_mag = diff[S] ? diff_neg[S-1:0] : diff[S-1:0];

    // Error combinations for the three terms
    assign d_p = {e_cur_reg[EW-1], e_cur_reg} - {e2_reg[EW-1], e2_reg};
    assign s_i = {{2{e_cur_reg[EW-1]}}, e_cur_reg} + {e1_reg[EW-1], e1_reg, 1'b0}
               + {{2{e2_reg[EW-1]}}, e2_reg};
    assign s_d = {{2{e_cur_reg[EW-1]}}, e_cur_reg} - {e1_reg[EW-1], e1_reg, 1'b0}
               + {{2{e2_reg[EW-1]}}, e2_reg};
    assign d_p_neg = -d_p;
    assign s_i_neg = -s_i;
    assign s_d_neg = -s_d;
    assign d_p_abs = d_p[F+2] ? d_p_neg[MAG_W-1:0] : d_p[MAG_W-1:0];
    assign s_i_abs = s_i[F+3] ? s_i_neg[MAG_W-1:0] : s_i[MAG_W-1:0];
    assign s_d_abs = s_d[F+3] ? s_d_neg[MAG_W-1:0] : s_d[MAG_W-1:0];

    // Signed error from the divider quotient
    assign e_mag     = {1'b0, div_quo[F:0]};
    assign e_mag_neg = -e_mag;

    // Rounded proportional term and divider term, both as magnitudes
    assign ob_ext  = {{(SUM_W-YW){ob_reg[YW-1]}}, ob_reg};
    assign p_round = mul_prod + {{(PROD_W-P_SHIFT){1'b0}}, P_HALF};
    assign p_term  = {{(SUM_W-PROD_W+P_SHIFT){1'b0}}, p_round[PROD_W-1:P_SHIFT]};
    assign q_term  = div_quo[SUM_W-1:0];

    // Saturate the sum to 32 bits
    assign sat_fit = (acc_reg[SUM_W-1:YW-1] == {(SUM_W-YW+1){acc_reg[SUM_W-1]}});
    assign y_sat   = sat_fit ? acc_reg[YW-1:0]
                   : (acc_reg[SUM_W-1] ? {1'b1, {(YW-1){1'b0}}} : {1'b0, {(YW-1){1'b1}}});

    // Clamp the latest output to [0,1] and scale to the converter range
    assign y_low     = ol_reg[YW-1];
    assign y_high    = !ol_reg[YW-1] && (ol_reg[YW-2:0] > ONE_FIXED);
    assign y_scaled  = {ol_reg[F:0], {S{1'b0}}} - {{S{1'b0}}, ol_reg[F:0]};
    assign drive_val = y_high ? FULL_SCALE : (y_low ? '0 : y_scaled[F+S-1:F]);

    // Select operands for the serial units
    always_comb begin
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        case (state_reg)
            ST_E0_GO: begin
                div_start = 1'b1;
                div_num   = {{(PROD_W-S-F){1'b0}}, diff_mag, {F{1'b0}}}
                          + {{(PROD_W-S){1'b0}}, HALF_FS};
                div_den   = {{(DIV_D_W-S){1'b0}}, FULL_SCALE};
            end
            ST_P_GO: begin
                mul_start = 1'b1;
                mul_a     = {{(COEF_W-GAIN_W){1'b0}}, gain_prop_reg};
                mul_b     = d_p_abs;
            end
            ST_I1_GO: begin
                mul_start = 1'b1;
                mul_a     = {{(COEF_W-GAIN_W){1'b0}}, gain_integral_reg};
                mul_b     = {{(MAG_W-PERIOD_W){1'b0}}, per_eff};
            end
            ST_I2_GO: begin
                mul_start = 1'b1;
                mul_a     = mul_prod[COEF_W-1:0];
                mul_b     = s_i_abs;
            end
            ST_I3_GO: begin
                div_start = 1'b1;
                div_num   = mul_prod + {{(PROD_W-DIV_D_W){1'b0}}, I_HALF};
                div_den   = I_DIVISOR;
            end
            ST_D1_GO: begin
                mul_start = 1'b1;
                mul_a     = {{(COEF_W-GAIN_W){1'b0}}, gain_derivative_reg};
                mul_b     = {{(MAG_W-D_SCALE_W){1'b0}}, D_SCALE};
            end
            ST_D2_GO: begin
                mul_start = 1'b1;
                mul_a     = mul_prod[COEF_W-1:0];
                mul_b     = s_d_abs;
            end
            ST_D3_GO: begin
                div_start = 1'b1;
                div_num   = mul_prod
                          + {{(PROD_W-PERIOD_W-P_SHIFT+1){1'b0}}, per_eff,
                             {(P_SHIFT-1){1'b0}}};
                div_den   = {{(DIV_D_W-PERIOD_W-P_SHIFT){1'b0}}, per_eff, {P_SHIFT{1'b0}}};
            end
            default: ;
        endcase
    end

    // Sequence one sample request through the serial units
    always_comb begin
        state_next   = state_reg;
        meas_next    = meas_reg;
        e_cur_next   = e_cur_reg;
        e1_next      = e1_reg;
        e2_next      = e2_reg;
        ol_next      = ol_reg;
        ob_next      = ob_reg;
        acc_next     = acc_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_data.req_type == REQ_CLEAR) begin
                        e1_next = '0;
                        e2_next = '0;
                        ol_next = '0;
                        ob_next = '0;
                    end else if (run_reg) begin
                        meas_next  = s_data.measurement;
                        state_next = ST_E0_GO;
                    end
                end
            end
            ST_E0_GO: state_next = ST_E0_WT;
            ST_E0_WT: begin
                if (div_stat.done) begin
                    e_cur_next = diff[S] ? e_mag_neg : e_mag;
                    state_next = ST_P_GO;
                end
            end
            ST_P_GO: state_next = ST_P_WT;
            ST_P_WT: begin
                if (mul_stat.done) begin
                    acc_next   = d_p[F+2] ? (ob_ext - p_term) : (ob_ext + p_term);
                    state_next = ST_I1_GO;
                end
            end
            ST_I1_GO: state_next = ST_I1_WT;
            ST_I1_WT: if (mul_stat.done) state_next = ST_I2_GO;
            ST_I2_GO: state_next = ST_I2_WT;
            ST_I2_WT: if (mul_stat.done) state_next = ST_I3_GO;
            ST_I3_GO: state_next = ST_I3_WT;
            ST_I3_WT: begin
                if (div_stat.done) begin
                    acc_next   = s_i[F+3] ? (acc_reg - q_term) : (acc_reg + q_term);
                    state_next = ST_D1_GO;
                end
            end
            ST_D1_GO: state_next = ST_D1_WT;
            ST_D1_WT: if (mul_stat.done) state_next = ST_D2_GO;
            ST_D2_GO: state_next = ST_D2_WT;
            ST_D2_WT: if (mul_stat.done) state_next = ST_D3_GO;
            ST_D3_GO: state_next = ST_D3_WT;
            ST_D3_WT: begin
                if (div_stat.done) begin
                    acc_next   = s_d[F+3] ? (acc_reg - q_term) : (acc_reg + q_term);
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                // Advance the history with the saturated output
                e2_next    = e1_reg;
                e1_next    = e_cur_reg;
                ob_next    = ol_reg;
                ol_next    = y_sat;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next             = 1'b1;
                    m_data_next.drive        = drive_val;
                    m_data_next.clamped_high = y_high;
                    m_data_next.clamped_low  = y_low;
                    state_next               = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control and history registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            e1_reg      <= '0;
            e2_reg      <= '0;
            ol_reg      <= '0;
            ob_reg      <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            e1_reg      <= e1_next;
            e2_reg      <= e2_next;
            ol_reg      <= ol_next;
            ob_reg      <= ob_next;
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        meas_reg   <= meas_next;
        e_cur_reg  <= e_cur_next;
        acc_reg    <= acc_next;
        m_data_reg <= m_data_next;
    end

    dpv_ser_mul #(
        .A_W (COEF_W),
        .B_W (MAG_W)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .stat    (mul_stat),
        .product (mul_prod)
    );

    dpv_ser_div #(
        .N_W (PROD_W),
        .D_W (DIV_D_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .num      (div_num),
        .den      (div_den),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    // The two serial units never run at once
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(mul_stat.busy && div_stat.busy))
        else $error("multiplier and divider busy together");

    // A multiplier result lands only while the sequencer waits for it
    assert property (@(posedge aclk) disable iff (!aresetn)
        mul_stat.done |-> (state_reg == ST_P_WT || state_reg == ST_I1_WT ||
                           state_reg == ST_I2_WT || state_reg == ST_D1_WT ||
                           state_reg == ST_D2_WT))
        else $error("multiplier result outside a wait state");

    // A clear request empties the history
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.req_type == REQ_CLEAR) |=>
        (e1_reg == '0 && e2_reg == '0 && ol_reg == '0 && ob_reg == '0))
        else $error("history not cleared");

    // A waiting result is never overwritten
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && m_valid_reg && !m_ready) |=> (state_reg == ST_OUT))
        else $error("result loaded over a pending one");

endmodule
`default_nettype wire

/* sv/dpv_ser_mul.sv */
`timescale 1ns / 1ps
`default_nettype none
module dpv_ser_mul
    import dpv_pkg::*;
#(
    parameter int A_W = 27,
    parameter int B_W = 19
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   start,
    input  wire  [A_W-1:0]        a,
    input  wire  [B_W-1:0]        b,
    output dpv_unit_stat_t        stat,
    output logic [A_W+B_W-1:0]    product
);

    localparam int P_W   = A_W + B_W;
    localparam int CNT_W = $clog2(B_W + 1);

    logic [A_W-1:0]   a_reg;
    logic [P_W-1:0]   prod_reg;
    logic [CNT_W-1:0] count_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [A_W:0]     upper_sum;

    // Add the multiplicand when the lowest multiplier bit is set
    assign upper_sum = {1'b0, prod_reg[P_W-1:B_W]} + (prod_reg[0] ? {1'b0, a_reg} : '0);

    // Control: count one multiplier bit per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg  <= 1'b1;
                count_reg <= CNT_W'(B_W);
            end else if (busy_reg) begin
                count_reg <= count_reg - 1'b1;
                if (count_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift the partial product right
    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg    <= a;
            prod_reg <= {{A_W{1'b0}}, b};
        end else if (busy_reg) begin
            prod_reg <= {upper_sum, prod_reg[B_W-1:1]};
        end
    end

    assign stat    = '{busy: busy_reg, done: done_reg};
    assign product = prod_reg;

endmodule
`default_nettype wire

/* sv/dpv_ser_div.sv */
`timescale 1ns / 1ps
`default_nettype none
module dpv_ser_div
    import dpv_pkg::*;
#(
    parameter int N_W = 46,
    parameter int D_W = 19
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               start,
    input  wire  [N_W-1:0]    num,
    input  wire  [D_W-1:0]    den,
    output dpv_unit_stat_t    stat,
    output logic [N_W-1:0]    quotient
);

    localparam int CNT_W = $clog2(N_W + 1);

    logic [D_W-1:0]   rem_reg;
    logic [N_W-1:0]   quo_reg;
    logic [D_W-1:0]   den_reg;
    logic [CNT_W-1:0] count_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [D_W:0]     shifted;
    logic [D_W+1:0]   trial;
    logic             fits;

    // Trial subtract of the divisor from the partial remainder
    assign shifted = {rem_reg, quo_reg[N_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, den_reg};
    assign fits    = !trial[D_W+1];

    // Control: one quotient bit per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg  <= 1'b1;
                count_reg <= CNT_W'(N_W);
            end else if (busy_reg) begin
                count_reg <= count_reg - 1'b1;
                if (count_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: restoring division, numerator shifts out as quotient shifts in
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end else if (busy_reg) begin
            rem_reg <= fits ? trial[D_W-1:0] : shifted[D_W-1:0];
            quo_reg <= {quo_reg[N_W-2:0], fits};
        end
    end

    assign stat     = '{busy: busy_reg, done: done_reg};
    assign quotient = quo_reg;

endmodule
`default_nettype wire
